### hdl/olg_pkg.sv
// Shared types and constants for the object list gate / dedup packer.
// No dependencies; every other file in hdl/ except olg_ifs.sv imports this package.
package olg_pkg;

	localparam int MAX_OBJECTS_DEF = 16;

	// Fixed widths of the result fields
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	// Configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Wanted sign codes and the fixed row values of a sign
	localparam logic [7:0]  SIGN_SIGNALS    = 8'd164;
	localparam logic [7:0]  SIGN_STOP_AHEAD = 8'd196;
	localparam logic [11:0] SIGN_LENGTH_CM  = 12'd100;
	localparam logic [7:0]  SIGN_CLASS      = 8'd1;

	// Register reset values
	localparam logic [14:0] MAX_RANGE_RST = 15'd13000;
	localparam logic [9:0]  DUP_LONG_RST  = 10'd150;
	localparam logic [9:0]  DUP_LAT_RST   = 10'd80;
	localparam logic [9:0]  MIN_LEN_RST   = 10'd50;
	localparam logic [7:0]  PED_CLASS_RST = 8'd5;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DYN   = 2'd1,
		ACT_STAT  = 2'd2,
		ACT_SIGN  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_ACCEPT  = 3'd0,
		STS_INVALID = 3'd1,
		STS_DUP     = 3'd2,
		STS_FULL    = 3'd3,
		STS_IGNORED = 3'd4,
		STS_CLEARED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_MAX_RANGE = 3'd0,
		REG_DUP_LONG  = 3'd1,
		REG_DUP_LAT   = 3'd2,
		REG_MIN_LEN   = 3'd3,
		REG_PED_CLASS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [14:0] max_range_cm;
		logic [9:0]  dup_long_window_cm;
		logic [9:0]  dup_lat_window_cm;
		logic [9:0]  min_length_cm;
		logic [7:0]  pedestrian_class;
	} cfg_t;

	// Classified item handed from the front end to the back end
	typedef struct packed {
		action_t            action;
		logic               rej;        // rejected before the duplicate walk
		status_t            rej_status;
		logic signed [15:0] long_dist;
		logic signed [13:0] lat_dist;
		logic signed [13:0] row_speed;
		logic [11:0]        row_length;
		logic [7:0]         row_class;
		logic signed [12:0] row_heading;
		logic               row_is_ped;
	} item_t;

endpackage

### hdl/olg_ifs.sv
// Valid/ready channel interfaces for candidate items and packed rows.
// Depends on nothing; field widths follow the item and row layouts.
interface olg_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [7:0]         obj_id;
	logic signed [15:0] long_dist;
	logic signed [13:0] lat_dist;
	logic signed [13:0] rel_speed;
	logic [11:0]        obj_length;
	logic [7:0]         obj_class;
	logic signed [12:0] heading_mrad;
	logic [7:0]         sign_code;

	modport source(output valid, action, obj_id, long_dist, lat_dist, rel_speed,
		obj_length, obj_class, heading_mrad, sign_code, input ready);
	modport sink(input valid, action, obj_id, long_dist, lat_dist, rel_speed,
		obj_length, obj_class, heading_mrad, sign_code, output ready);
endinterface

interface olg_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [5:0]         slot;
	logic [14:0]        row_long;
	logic signed [13:0] row_lat;
	logic signed [13:0] row_speed;
	logic [11:0]        row_length;
	logic [7:0]         row_class;
	logic signed [12:0] row_heading;
	logic               row_is_ped;
	logic [6:0]         packed_count;

	modport source(output valid, status, slot, row_long, row_lat, row_speed,
		row_length, row_class, row_heading, row_is_ped, packed_count, input ready);
	modport sink(input valid, status, slot, row_long, row_lat, row_speed,
		row_length, row_class, row_heading, row_is_ped, packed_count, output ready);
endinterface

### hdl/object_list_gate_dedup_packer.sv
// Object list gate and packer. Each candidate beat yields exactly one result
// beat. Frame-start and pre-rejected items skip the table walk; an object or
// sign that reaches the duplicate check walks every entry already packed in
// the position table through its single read port (one entry a cycle). A
// two-entry queue lets new candidates be taken while the back end walks, and
// a finished result waits in an output register without stopping the next
// walk. Configure over APB only when idle.
module object_list_gate_dedup_packer
	import olg_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	olg_in_if.sink             obj_in,
	olg_out_if.source          row_out
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	item_t    wr_item;
	item_t    rd_item;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_range_cm       <= MAX_RANGE_RST;
			cfg_q.dup_long_window_cm <= DUP_LONG_RST;
			cfg_q.dup_lat_window_cm  <= DUP_LAT_RST;
			cfg_q.min_length_cm      <= MIN_LEN_RST;
			cfg_q.pedestrian_class   <= PED_CLASS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MAX_RANGE: cfg_q.max_range_cm       <= pwdata[14:0];
				REG_DUP_LONG:  cfg_q.dup_long_window_cm <= pwdata[9:0];
				REG_DUP_LAT:   cfg_q.dup_lat_window_cm  <= pwdata[9:0];
				REG_MIN_LEN:   cfg_q.min_length_cm      <= pwdata[9:0];
				REG_PED_CLASS: cfg_q.pedestrian_class   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_RANGE: prdata = {17'd0, cfg_q.max_range_cm};
			REG_DUP_LONG:  prdata = {22'd0, cfg_q.dup_long_window_cm};
			REG_DUP_LAT:   prdata = {22'd0, cfg_q.dup_lat_window_cm};
			REG_MIN_LEN:   prdata = {22'd0, cfg_q.min_length_cm};
			REG_PED_CLASS: prdata = {24'd0, cfg_q.pedestrian_class};
			default:       prdata = '0;
		endcase
	end

	olg_front u_front (
		.cfg    (cfg_q),
		.obj_in (obj_in),
		.q_full (q_full),
		.push   (push),
		.item   (wr_item)
	);

	olg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.rd_item (rd_item)
	);

	olg_back #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.rd_item (rd_item),
		.pop     (pop),
		.row_out (row_out)
	);

endmodule

### hdl/olg_front.sv
// Front end: takes candidate beats, applies the id / range / sign-code gates
// and builds the normalized row. Depends on olg_pkg and olg_in_if.
module olg_front
	import olg_pkg::*;
(
	input  cfg_t       cfg,
	olg_in_if.sink     obj_in,
	input  logic       q_full,
	output logic       push,
	output item_t      item
);

	action_t act;
	logic    range_bad;
	logic    id_bad;
	logic    sign_ok;

	assign obj_in.ready = !q_full;
	assign push         = obj_in.valid && obj_in.ready;

	always_comb begin
		act       = action_t'(obj_in.action);
		range_bad = obj_in.long_dist[15] || (obj_in.long_dist[14:0] > cfg.max_range_cm);
		id_bad    = (obj_in.obj_id == 8'd0);
		sign_ok   = (obj_in.sign_code == SIGN_SIGNALS) || (obj_in.sign_code == SIGN_STOP_AHEAD);

		item.action     = act;
		item.long_dist  = obj_in.long_dist;
		item.lat_dist   = obj_in.lat_dist;
		item.rej        = 1'b0;
		item.rej_status = STS_INVALID;

		item.row_speed   = (act == ACT_DYN) ? obj_in.rel_speed : 14'sd0;
		item.row_length  = (obj_in.obj_length < {2'b00, cfg.min_length_cm}) ?
			{2'b00, cfg.min_length_cm} : obj_in.obj_length;
		item.row_class   = obj_in.obj_class;
		item.row_heading = obj_in.heading_mrad;
		item.row_is_ped  = (obj_in.obj_class == cfg.pedestrian_class);

		case (act)
			ACT_CLEAR: begin
				item.rej = 1'b0;
			end
			ACT_DYN, ACT_STAT: begin
				item.rej = id_bad || range_bad;
			end
			ACT_SIGN: begin
				if (!sign_ok) begin
					item.rej        = 1'b1;
					item.rej_status = STS_IGNORED;
				end else begin
					item.rej = range_bad;
				end
				item.row_length  = SIGN_LENGTH_CM;
				item.row_class   = SIGN_CLASS;
				item.row_heading = 13'sd0;
				item.row_is_ped  = 1'b0;
			end
			default: begin
				item.rej = 1'b0;
			end
		endcase
	end

endmodule

### hdl/olg_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on olg_pkg.
module olg_queue
	import olg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t rd_item
);

	item_t      store_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_item = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### hdl/olg_back.sv
// Back end: walks the packed position table for near-duplicates, applies the
// full check, writes the table and holds the result beat. Depends on olg_pkg
// and olg_out_if.
module olg_back
	import olg_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  item_t     rd_item,
	output logic      pop,
	olg_out_if.source row_out
);

	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

	back_state_t state_q, state_d;
	item_t       cur_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic        rd_vld_q;
	logic        dup_q;
	logic        out_valid_q;

	// table entry: long distance in [29:14], lateral in [13:0]
	logic [29:0] mem [MAX_OBJECTS];
	logic [29:0] rd_data_q;

	logic               issuing;
	logic               commit;
	logic               full;
	logic               near;
	logic signed [16:0] dl;
	logic signed [14:0] dt;
	logic [16:0]        dl_abs;
	logic [14:0]        dt_abs;
	status_t            status;
	logic [CNT_W-1:0]   total_d;

	always_comb begin
		issuing = (state_q == BK_SCAN) && (scan_idx_q < total_q);
		commit  = (state_q == BK_FIN) && (!out_valid_q || row_out.ready);
		pop     = (state_q == BK_IDLE) && !q_empty;
		full    = (total_q >= CNT_W'(MAX_OBJECTS));

		dl     = {rd_data_q[29], rd_data_q[29:14]} - {cur_q.long_dist[15], cur_q.long_dist};
		dt     = {rd_data_q[13], rd_data_q[13:0]} - {cur_q.lat_dist[13], cur_q.lat_dist};
		dl_abs = dl[16] ? 17'(-dl) : 17'(dl);
		dt_abs = dt[14] ? 15'(-dt) : 15'(dt);
		near   = (dl_abs < {7'd0, cfg.dup_long_window_cm}) &&
			(dt_abs < {5'd0, cfg.dup_lat_window_cm});

		// check order differs: a dynamic object tests full before anything else
		status = STS_ACCEPT;
		case (cur_q.action)
			ACT_CLEAR: status = STS_CLEARED;
			ACT_DYN: begin
				if (full) status = STS_FULL;
				else if (cur_q.rej) status = cur_q.rej_status;
				else if (dup_q) status = STS_DUP;
				else status = STS_ACCEPT;
			end
			default: begin
				if (cur_q.rej) status = cur_q.rej_status;
				else if (dup_q) status = STS_DUP;
				else if (full) status = STS_FULL;
				else status = STS_ACCEPT;
			end
		endcase

		if (cur_q.action == ACT_CLEAR) begin
			total_d = '0;
		end else if (status == STS_ACCEPT) begin
			total_d = total_q + CNT_W'(1);
		end else begin
			total_d = total_q;
		end

		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					state_d = (rd_item.action != ACT_CLEAR && !rd_item.rej) ? BK_SCAN : BK_FIN;
				end
			end
			BK_SCAN: begin
				if (!issuing && !rd_vld_q) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (commit) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			total_q     <= '0;
			scan_idx_q  <= '0;
			rd_vld_q    <= 1'b0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issuing;
			if (pop) begin
				scan_idx_q <= '0;
				dup_q      <= 1'b0;
			end else begin
				if (issuing) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				if (rd_vld_q && near) begin
					dup_q <= 1'b1;
				end
			end
			if (commit) begin
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (row_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_item;
		end
		if (issuing) begin
			rd_data_q <= mem[scan_idx_q[IDX_W-1:0]];
		end
		if (commit && status == STS_ACCEPT) begin
			mem[total_q[IDX_W-1:0]] <= {cur_q.long_dist, cur_q.lat_dist};
		end
	end

	// result beat register
	logic [2:0]         status_q;
	logic [5:0]         slot_q;
	logic [14:0]        row_long_q;
	logic signed [13:0] row_lat_q;
	logic signed [13:0] row_speed_q;
	logic [11:0]        row_length_q;
	logic [7:0]         row_class_q;
	logic signed [12:0] row_heading_q;
	logic               row_is_ped_q;
	logic [6:0]         packed_count_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q       <= status;
			packed_count_q <= COUNT_W'(total_d);
			if (status == STS_ACCEPT) begin
				slot_q        <= SLOT_W'(total_q);
				row_long_q    <= cur_q.long_dist[14:0];
				row_lat_q     <= cur_q.lat_dist;
				row_speed_q   <= cur_q.row_speed;
				row_length_q  <= cur_q.row_length;
				row_class_q   <= cur_q.row_class;
				row_heading_q <= cur_q.row_heading;
				row_is_ped_q  <= cur_q.row_is_ped;
			end else begin
				slot_q        <= '0;
				row_long_q    <= '0;
				row_lat_q     <= '0;
				row_speed_q   <= '0;
				row_length_q  <= '0;
				row_class_q   <= '0;
				row_heading_q <= '0;
				row_is_ped_q  <= 1'b0;
			end
		end
	end

	assign row_out.valid        = out_valid_q;
	assign row_out.status       = status_q;
	assign row_out.slot         = slot_q;
	assign row_out.row_long     = row_long_q;
	assign row_out.row_lat      = row_lat_q;
	assign row_out.row_speed    = row_speed_q;
	assign row_out.row_length   = row_length_q;
	assign row_out.row_class    = row_class_q;
	assign row_out.row_heading  = row_heading_q;
	assign row_out.row_is_ped   = row_is_ped_q;
	assign row_out.packed_count = packed_count_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_OBJECTS))
		else $error("packed total beyond table depth");

	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STS_ACCEPT |->
			packed_count_q == slot_q + 7'd1)
		else $error("accepted beat count does not follow slot");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != STS_ACCEPT |->
			slot_q == 6'd0 && row_length_q == 12'd0 && row_class_q == 8'd0)
		else $error("rejected beat carries row data");

	a_scan_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> cur_q.action != ACT_CLEAR && !cur_q.rej)
		else $error("table walk for an item that needs none");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == BK_IDLE && out_valid_q)
		else $error("commit did not present a result");

endmodule
